// ===== src/positional_list_engine_macros.svh =====
// Assertion macros shared by the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Checked only outside reset.
`define PLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define PLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ple_pkg.sv =====
// Types and constants of the positional list engine.
package ple_pkg;

    localparam int POS_W = 6;

    localparam logic [2:0] OP_APPEND   = 3'd0;
    localparam logic [2:0] OP_INSERT   = 3'd1;
    localparam logic [2:0] OP_DELETE   = 3'd2;
    localparam logic [2:0] OP_SWAP     = 3'd3;
    localparam logic [2:0] OP_READ_FWD = 3'd4;
    localparam logic [2:0] OP_READ_BWD = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value_in;
        logic [POS_W-1:0]   pos_a;
        logic [POS_W-1:0]   pos_b;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_out;
        logic [POS_W-1:0]   index_out;
        logic               last;
    } rsp_t;

    typedef enum logic [2:0] {
        CM_HOLD,
        CM_LOAD,
        CM_INSERT,
        CM_DELETE,
        CM_ROT_LEFT,
        CM_ROT_RIGHT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t         mode;
        logic [POS_W-1:0]   pos;
        logic signed [31:0] value;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SKIP,
        S_EMIT,
        S_SCAN,
        S_WRITE,
        S_FINISH
    } state_t;

endpackage

// ===== src/ple_cell.sv =====
// One list cell: holds one entry and trades it with its neighbors.
module ple_cell (
    input  logic                      clk,
    input  ple_pkg::cell_ctrl_t       ctrl,
    input  logic [ple_pkg::POS_W-1:0] cell_idx,
    input  logic signed [31:0]        left,
    input  logic signed [31:0]        right,
    output logic signed [31:0]        value
);
    import ple_pkg::*;

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    always_comb
    begin
        unique case (ctrl.mode)
            CM_HOLD:      value_next = value_reg;
            CM_LOAD:      value_next = (cell_idx == ctrl.pos) ? ctrl.value : value_reg;
            CM_INSERT:
            begin
                if (cell_idx == ctrl.pos)
                    value_next = ctrl.value;
                else if (cell_idx > ctrl.pos)
                    value_next = left;
                else
                    value_next = value_reg;
            end
            CM_DELETE:    value_next = (cell_idx >= ctrl.pos) ? right : value_reg;
            CM_ROT_LEFT:  value_next = right;
            CM_ROT_RIGHT: value_next = left;
            default:      value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== src/positional_list_engine.sv =====
// Top level of the positional list engine: cell row and request sequencer.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------
//  request | req_valid | req_stall | req (ple_pkg::req_t)
//  result  | rsp_valid | rsp_stall | rsp (ple_pkg::rsp_t)
//
// Append, insert, delete and error cases: no ring pass, cells update in parallel.
// Reads: the ring makes a full turn, one entry per emit cycle while not stalled.
// Swap: two ring passes (capture, then write back), then a finish state.
// A request is held in a command register, so a new one is taken while a result waits.
// rsp_stall freezes the ring only during emit cycles. Reset empties the list.
`include "positional_list_engine_macros.svh"

module positional_list_engine #(
    parameter int DEPTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ple_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ple_pkg::rsp_t rsp
);
    import ple_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      step_reg, step_next;
    logic               cmd_valid_reg, cmd_valid_next;
    req_t               cmd_reg;
    logic signed [31:0] swap_a_reg, swap_b_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic signed [31:0] cell_val [DEPTH];
    logic signed [31:0] left_val [DEPTH];
    logic signed [31:0] right_val [DEPTH];
    logic signed [31:0] wrap_val;
    logic signed [31:0] emit_val;
    cell_ctrl_t         cell_ctrl;

    logic               req_accept;
    logic               slot_free;
    logic               cmd_done;
    logic               rsp_load;
    logic               cap_a, cap_b;
    logic               full, empty, is_bwd;
    logic [XW-1:0]      n_x, pa_x, pb_x, step_x, step_inc_x;
    logic               at_a, at_b;

    // decode of the pending request for edits that need no ring pass
    logic               single;
    logic [1:0]         single_st;
    cell_mode_t         edit_mode;
    logic [POS_W-1:0]   edit_pos;
    logic               cnt_inc, cnt_dec;

    assign slot_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = cmd_valid_reg && !cmd_done;
    assign req_accept = req_valid && !req_stall;

    assign full       = (count_reg == CW'(DEPTH));
    assign empty      = (count_reg == '0);
    assign is_bwd     = (cmd_reg.opcode == OP_READ_BWD);
    assign n_x        = XW'(count_reg);
    assign pa_x       = XW'(cmd_reg.pos_a);
    assign pb_x       = XW'(cmd_reg.pos_b);
    assign step_x     = XW'(step_reg);
    assign step_inc_x = step_x + XW'(1);
    assign at_a       = (step_inc_x == pa_x);
    assign at_b       = (step_inc_x == pb_x);
    assign emit_val   = is_bwd ? cell_val[DEPTH-1] : cell_val[0];

    // ring of cells
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            assign left_val[g] = cell_val[DEPTH-1];
        end
        else
        begin : g_mid_l
            assign left_val[g] = cell_val[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign right_val[g] = wrap_val;
        end
        else
        begin : g_mid_r
            assign right_val[g] = cell_val[g+1];
        end

        ple_cell u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl),
            .cell_idx (POS_W'(g)),
            .left     (left_val[g]),
            .right    (right_val[g]),
            .value    (cell_val[g])
        );
    end

    always_comb
    begin
        single    = 1'b1;
        single_st = ST_RANGE;
        edit_mode = CM_HOLD;
        edit_pos  = '0;
        cnt_inc   = 1'b0;
        cnt_dec   = 1'b0;
        unique case (cmd_reg.opcode)
            OP_APPEND:
            begin
                if (full)
                    single_st = ST_FULL;
                else
                begin
                    single_st = ST_OK;
                    edit_mode = CM_LOAD;
                    edit_pos  = POS_W'(count_reg);
                    cnt_inc   = 1'b1;
                end
            end
            OP_INSERT:
            begin
                if (cmd_reg.pos_a == '0 || pa_x > n_x + XW'(1))
                    single_st = ST_RANGE;
                else if (full)
                    single_st = ST_FULL;
                else
                begin
                    single_st = ST_OK;
                    edit_mode = CM_INSERT;
                    edit_pos  = cmd_reg.pos_a - POS_W'(1);
                    cnt_inc   = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (empty)
                    single_st = ST_EMPTY;
                else if (cmd_reg.pos_a == '0 || pa_x > n_x)
                    single_st = ST_RANGE;
                else
                begin
                    single_st = ST_OK;
                    edit_mode = CM_DELETE;
                    edit_pos  = cmd_reg.pos_a - POS_W'(1);
                    cnt_dec   = 1'b1;
                end
            end
            OP_SWAP:
            begin
                if (empty)
                    single_st = ST_EMPTY;
                else if (cmd_reg.pos_a == '0 || pa_x > n_x ||
                         cmd_reg.pos_b == '0 || pb_x > n_x)
                    single_st = ST_RANGE;
                else
                    single = 1'b0;
            end
            OP_READ_FWD, OP_READ_BWD:
            begin
                if (empty)
                    single_st = ST_EMPTY;
                else
                    single = 1'b0;
            end
            default: single_st = ST_RANGE;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd_done   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid_reg)
                begin
                    if (single)
                        cmd_done = slot_free;
                    else
                    begin
                        step_next = '0;
                        if (cmd_reg.opcode == OP_SWAP)
                            state_next = S_SCAN;
                        else if (is_bwd && !full)
                            state_next = S_SKIP;
                        else
                            state_next = S_EMIT;
                    end
                end
            end
            S_SKIP:
            begin
                if (step_inc_x == XW'(DEPTH) - n_x)
                begin
                    step_next = '0;
                    if (is_bwd)
                        state_next = S_EMIT;
                    else
                    begin
                        state_next = S_IDLE;
                        cmd_done   = 1'b1;
                    end
                end
                else
                    step_next = step_reg + CW'(1);
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    if (step_inc_x == n_x)
                    begin
                        step_next = '0;
                        if (!is_bwd && !full)
                            state_next = S_SKIP;
                        else
                        begin
                            state_next = S_IDLE;
                            cmd_done   = 1'b1;
                        end
                    end
                    else
                        step_next = step_reg + CW'(1);
                end
            end
            S_SCAN:
            begin
                if (step_inc_x == XW'(DEPTH))
                begin
                    step_next  = '0;
                    state_next = S_WRITE;
                end
                else
                    step_next = step_reg + CW'(1);
            end
            S_WRITE:
            begin
                if (step_inc_x == XW'(DEPTH))
                begin
                    step_next  = '0;
                    state_next = S_FINISH;
                end
                else
                    step_next = step_reg + CW'(1);
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                    cmd_done   = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cell_ctrl.mode  = CM_HOLD;
        cell_ctrl.pos   = edit_pos;
        cell_ctrl.value = cmd_reg.value_in;
        wrap_val        = cell_val[0];
        rsp_load        = 1'b0;
        rsp_next.status    = ST_OK;
        rsp_next.value_out = '0;
        rsp_next.index_out = '0;
        rsp_next.last      = 1'b1;
        cap_a      = 1'b0;
        cap_b      = 1'b0;
        count_next = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid_reg && single && slot_free)
                begin
                    cell_ctrl.mode  = edit_mode;
                    rsp_load        = 1'b1;
                    rsp_next.status = single_st;
                    if (cnt_inc)
                        count_next = count_reg + CW'(1);
                    else if (cnt_dec)
                        count_next = count_reg - CW'(1);
                end
            end
            S_SKIP:
            begin
                cell_ctrl.mode = is_bwd ? CM_ROT_RIGHT : CM_ROT_LEFT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cell_ctrl.mode     = is_bwd ? CM_ROT_RIGHT : CM_ROT_LEFT;
                    rsp_load           = 1'b1;
                    rsp_next.value_out = emit_val;
                    rsp_next.index_out = is_bwd ? POS_W'(n_x - step_x) : POS_W'(step_inc_x);
                    rsp_next.last      = (step_inc_x == n_x);
                end
            end
            S_SCAN:
            begin
                // cell 0 holds the entry at position step+1
                cell_ctrl.mode = CM_ROT_LEFT;
                cap_a          = at_a;
                cap_b          = at_b;
            end
            S_WRITE:
            begin
                cell_ctrl.mode = CM_ROT_LEFT;
                if (at_a)
                    wrap_val = swap_b_reg;
                else if (at_b)
                    wrap_val = swap_a_reg;
            end
            S_FINISH:
            begin
                rsp_load = slot_free;
            end
            default: cell_ctrl.mode = CM_HOLD;
        endcase
    end

    always_comb
    begin
        if (req_accept)
            cmd_valid_next = 1'b1;
        else if (cmd_done)
            cmd_valid_next = 1'b0;
        else
            cmd_valid_next = cmd_valid_reg;

        if (rsp_load)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            cmd_valid_reg <= cmd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
            cmd_reg <= req;
        if (rsp_load)
            rsp_reg <= rsp_next;
        if (cap_a)
            swap_a_reg <= cell_val[0];
        if (cap_b)
            swap_b_reg <= cell_val[0];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `PLE_ASSERT_ALWAYS(a_count_max, !rst_n || count_reg <= CW'(DEPTH), "entry count above depth")
    `PLE_ASSERT(a_busy_has_cmd, state_reg != S_IDLE |-> cmd_valid_reg, "sequencer busy with no request")
    `PLE_ASSERT(a_count_on_edit, !$stable(count_reg) |-> $past(state_reg == S_IDLE && cmd_valid_reg), "count changed outside an edit")
    `PLE_ASSERT(a_rsp_from_cmd, $rose(rsp_valid) |-> $past(cmd_valid_reg), "result without a pending request")

endmodule
